FILE: rtl/core/tdn_pkg.sv
// ----------------------------------------------------------------------------
// tdn_pkg
// Shared types and constants of the torus distance and normal core.
// ----------------------------------------------------------------------------
`default_nettype none

package tdn_pkg;

  // field widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned NORMAL_W = 16;
  localparam int unsigned RADIUS_W = 31;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAJOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MINOR = 1'b1;

  localparam logic [RADIUS_W-1:0] MAJOR_RESET = 31'd131072;
  localparam logic [RADIUS_W-1:0] MINOR_RESET = 31'd65536;

  // split multiplier
  localparam int unsigned LIMB_W  = 26;
  localparam int unsigned LIMBS   = 4;
  localparam int unsigned MUL_W   = LIMB_W * LIMBS;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned ROW_W   = LIMB_W * (LIMBS + 1);
  localparam int unsigned MUL_LAT = 3;

  // intermediate widths
  localparam int unsigned SQ_W   = 64;   // squares of coordinates and radii
  localparam int unsigned P_W    = 67;   // signed P and Q
  localparam int unsigned GM_W   = 98;   // gradient magnitudes
  localparam int unsigned F_W    = 130;  // signed implicit value
  localparam int unsigned G2_W   = 200;  // squared gradient length
  localparam int unsigned ROOT_W = 99;   // gradient length
  localparam int unsigned DIV_W  = 132;  // divider remainder
  localparam int unsigned QUO_W  = 32;   // quotient bits per lane
  localparam int unsigned LANES  = 4;    // distance and three normal lanes

  localparam int unsigned NORM_FRAC = NORMAL_W - 2;
  localparam logic [QUO_W-1:0] NORM_ONE = QUO_W'(1) << NORM_FRAC;
  localparam logic [QUO_W-1:0] DIST_NEG_LIM = QUO_W'(1) << (COORD_W - 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  distance;
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic                       degenerate;
    logic                       saturated;
  } out_item_t;

  // travels alongside the square root
  typedef struct packed {
    logic signed [F_W-1:0]     f;
    logic [2:0][GM_W-1:0]      gm;
    logic [2:0]                gneg;
  } sq_side_t;

  // travels alongside the divider
  typedef struct packed {
    logic       fneg;
    logic       ovf;
    logic       degen;
    logic [2:0] gneg;
  } div_side_t;

endpackage

`default_nettype wire

FILE: rtl/core/tdn_mul.sv
// ----------------------------------------------------------------------------
// tdn_mul
// Unsigned multiplier split into 26-bit limbs, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tdn_mul (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [tdn_pkg::MUL_W-1:0]  a_i,
  input  wire logic [tdn_pkg::MUL_W-1:0]  b_i,
  output logic      [tdn_pkg::PROD_W-1:0] p_o
);

  logic [tdn_pkg::LIMBS-1:0][tdn_pkg::LIMBS-1:0][2*tdn_pkg::LIMB_W-1:0] pp_d, pp_q;
  logic [tdn_pkg::LIMBS-1:0][tdn_pkg::ROW_W-1:0] row_d, row_q;
  logic [tdn_pkg::PROD_W-1:0] p_d, p_q;

  // limb partial products
  always_comb begin
    for (int i = 0; i < tdn_pkg::LIMBS; i++) begin
      for (int j = 0; j < tdn_pkg::LIMBS; j++) begin
        pp_d[i][j] = a_i[tdn_pkg::LIMB_W*i +: tdn_pkg::LIMB_W] *
                     b_i[tdn_pkg::LIMB_W*j +: tdn_pkg::LIMB_W];
      end
    end
  end

  // row sums
  always_comb begin
    for (int i = 0; i < tdn_pkg::LIMBS; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < tdn_pkg::LIMBS; j++) begin
        row_d[i] = row_d[i] + (tdn_pkg::ROW_W'(pp_q[i][j]) << (tdn_pkg::LIMB_W * j));
      end
    end
  end

  // final sum
  always_comb begin
    p_d = '0;
    for (int i = 0; i < tdn_pkg::LIMBS; i++) begin
      p_d = p_d + (tdn_pkg::PROD_W'(row_q[i]) << (tdn_pkg::LIMB_W * i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q  <= pp_d;
      row_q <= row_d;
      p_q   <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/core/tdn_sqrt.sv
// ----------------------------------------------------------------------------
// tdn_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tdn_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [tdn_pkg::G2_W-1:0]    rad_i,
  input  wire tdn_pkg::sq_side_t           side_i,
  output logic                             valid_o,
  output logic      [tdn_pkg::ROOT_W-1:0]  root_o,
  output tdn_pkg::sq_side_t                side_o
);

  localparam int unsigned STEPS = tdn_pkg::ROOT_W;

  logic [STEPS-1:0]                          v_q;
  logic [STEPS-1:0][tdn_pkg::G2_W-1:0]       rem_q;
  logic [STEPS-1:0][tdn_pkg::ROOT_W-1:0]     root_q;
  tdn_pkg::sq_side_t [STEPS-1:0]             side_q;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int unsigned BIT = STEPS - 1 - k;

    logic                         v_in;
    logic [tdn_pkg::G2_W-1:0]     rem_in, trial, rem_d;
    logic [tdn_pkg::ROOT_W-1:0]   root_in, root_d;
    tdn_pkg::sq_side_t            side_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // try setting this root bit
    always_comb begin
      trial  = (tdn_pkg::G2_W'(root_in) << (BIT + 1)) + (tdn_pkg::G2_W'(1) << (2 * BIT));
      rem_d  = rem_in;
      root_d = root_in;
      if (rem_in >= trial) begin
        rem_d       = rem_in - trial;
        root_d[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign root_o  = root_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/core/tdn_div.sv
// ----------------------------------------------------------------------------
// tdn_div
// Pipelined restoring divider, four lanes sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tdn_div (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire logic                                            en_i,
  input  wire logic                                            valid_i,
  input  wire logic [tdn_pkg::LANES-1:0][tdn_pkg::DIV_W-1:0]   num_i,
  input  wire logic [tdn_pkg::ROOT_W-1:0]                      den_i,
  input  wire tdn_pkg::div_side_t                              side_i,
  output logic                                                 valid_o,
  output logic      [tdn_pkg::LANES-1:0][tdn_pkg::QUO_W-1:0]   quo_o,
  output tdn_pkg::div_side_t                                   side_o
);

  localparam int unsigned STEPS = tdn_pkg::QUO_W;

  logic [STEPS-1:0]                                          v_q;
  logic [STEPS-1:0][tdn_pkg::LANES-1:0][tdn_pkg::DIV_W-1:0]  rem_q;
  logic [STEPS-1:0][tdn_pkg::LANES-1:0][tdn_pkg::QUO_W-1:0]  quo_q;
  logic [STEPS-1:0][tdn_pkg::ROOT_W-1:0]                     den_q;
  tdn_pkg::div_side_t [STEPS-1:0]                            side_q;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int unsigned BIT = STEPS - 1 - k;

    logic                                          v_in;
    logic [tdn_pkg::LANES-1:0][tdn_pkg::DIV_W-1:0] rem_in, rem_d;
    logic [tdn_pkg::LANES-1:0][tdn_pkg::QUO_W-1:0] quo_in, quo_d;
    logic [tdn_pkg::ROOT_W-1:0]                    den_in;
    logic [tdn_pkg::DIV_W-1:0]                     dsh;
    tdn_pkg::div_side_t                            side_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // compare and subtract the shifted divisor in every lane
    always_comb begin
      dsh   = tdn_pkg::DIV_W'(den_in) << BIT;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int l = 0; l < tdn_pkg::LANES; l++) begin
        if (rem_in[l] >= dsh) begin
          rem_d[l]      = rem_in[l] - dsh;
          quo_d[l][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign quo_o   = quo_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/core/torus_distance_and_normal_core.sv
// ----------------------------------------------------------------------------
// torus_distance_and_normal_core
// First-order distance estimate and unit gradient normal of a z-axis torus.
// ----------------------------------------------------------------------------
// throughput: one item per cycle; the whole pipeline advances together and
//   holds only while a result sits unaccepted in the output register
// depth is set by the 99-stage square root and the 32-stage divider
// reset: pipeline emptied, radii set to 2.0 and 1.0
`default_nettype none

module torus_distance_and_normal_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [tdn_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [tdn_pkg::RADIUS_W-1:0]        cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire tdn_pkg::in_item_t                   in_item_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output tdn_pkg::out_item_t                       out_item_o
);

  localparam int unsigned ML = tdn_pkg::MUL_LAT;

  logic adv;

  // configuration registers
  logic [tdn_pkg::RADIUS_W-1:0] major_q, minor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q <= tdn_pkg::MAJOR_RESET;
      minor_q <= tdn_pkg::MINOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tdn_pkg::REG_MAJOR: major_q <= cfg_data_i;
        tdn_pkg::REG_MINOR: minor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output holds an untaken item
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------- stage 0
  tdn_pkg::in_item_t s0_q;
  logic              v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= in_item_i;
    end
  end

  // coordinate magnitudes and signs
  logic [2:0][tdn_pkg::COORD_W-1:0] cabs;
  logic [2:0]                       cneg;

  always_comb begin
    cneg[0] = s0_q.point_x[tdn_pkg::COORD_W-1];
    cneg[1] = s0_q.point_y[tdn_pkg::COORD_W-1];
    cneg[2] = s0_q.point_z[tdn_pkg::COORD_W-1];
    cabs[0] = cneg[0] ? tdn_pkg::COORD_W'(-s0_q.point_x) : tdn_pkg::COORD_W'(s0_q.point_x);
    cabs[1] = cneg[1] ? tdn_pkg::COORD_W'(-s0_q.point_y) : tdn_pkg::COORD_W'(s0_q.point_y);
    cabs[2] = cneg[2] ? tdn_pkg::COORD_W'(-s0_q.point_z) : tdn_pkg::COORD_W'(s0_q.point_z);
  end

  // ---------------------------------------------------------- squares
  logic [4:0][tdn_pkg::MUL_W-1:0]  ma_in;
  logic [4:0][tdn_pkg::PROD_W-1:0] ma_p;

  always_comb begin
    ma_in[0] = tdn_pkg::MUL_W'(cabs[0]);
    ma_in[1] = tdn_pkg::MUL_W'(cabs[1]);
    ma_in[2] = tdn_pkg::MUL_W'(cabs[2]);
    ma_in[3] = tdn_pkg::MUL_W'(major_q);
    ma_in[4] = tdn_pkg::MUL_W'(minor_q);
  end

  for (genvar i = 0; i < 5; i++) begin : g_mul_a
    tdn_mul u_mul (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (ma_in[i]),
      .b_i   (ma_in[i]),
      .p_o   (ma_p[i])
    );
  end

  logic [ML-1:0]                             va_q;
  logic [ML-1:0][2:0][tdn_pkg::COORD_W-1:0]  abs_a_q;
  logic [ML-1:0][2:0]                        neg_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
    end else if (adv) begin
      va_q <= {va_q[ML-2:0], v0_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      abs_a_q <= {abs_a_q[ML-2:0], cabs};
      neg_a_q <= {neg_a_q[ML-2:0], cneg};
    end
  end

  // ---------------------------------------------------------- stage 1: P, Q
  logic [tdn_pkg::SQ_W-1:0]      radial, aa;
  logic signed [tdn_pkg::P_W-1:0] p_s, q_s;

  always_comb begin
    radial = ma_p[0][tdn_pkg::SQ_W-1:0] + ma_p[1][tdn_pkg::SQ_W-1:0];
    aa     = ma_p[3][tdn_pkg::SQ_W-1:0];
    p_s = $signed(tdn_pkg::P_W'(radial)) + $signed(tdn_pkg::P_W'(ma_p[2][tdn_pkg::SQ_W-1:0]))
        + $signed(tdn_pkg::P_W'(aa)) - $signed(tdn_pkg::P_W'(ma_p[4][tdn_pkg::SQ_W-1:0]));
    q_s = p_s - $signed(tdn_pkg::P_W'(aa) << 1);
  end

  logic                            v1_q;
  logic [tdn_pkg::SQ_W-1:0]        radial_q, aa_q;
  logic [tdn_pkg::P_W-1:0]         pabs_q, qabs_q;
  logic [2:0][tdn_pkg::COORD_W-1:0] cabs1_q;
  logic [2:0]                      gneg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= va_q[ML-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      radial_q   <= radial;
      aa_q       <= aa;
      pabs_q     <= p_s[tdn_pkg::P_W-1] ? tdn_pkg::P_W'(-p_s) : tdn_pkg::P_W'(p_s);
      qabs_q     <= q_s[tdn_pkg::P_W-1] ? tdn_pkg::P_W'(-q_s) : tdn_pkg::P_W'(q_s);
      cabs1_q    <= abs_a_q[ML-1];
      gneg1_q[0] <= neg_a_q[ML-1][0] ^ q_s[tdn_pkg::P_W-1];
      gneg1_q[1] <= neg_a_q[ML-1][1] ^ q_s[tdn_pkg::P_W-1];
      gneg1_q[2] <= neg_a_q[ML-1][2] ^ p_s[tdn_pkg::P_W-1];
    end
  end

  // ---------------------------------------------------------- gradient, F terms
  logic [4:0][tdn_pkg::MUL_W-1:0]  mb_a, mb_b;
  logic [4:0][tdn_pkg::PROD_W-1:0] mb_p;

  always_comb begin
    mb_a[0] = tdn_pkg::MUL_W'(cabs1_q[0]);  mb_b[0] = tdn_pkg::MUL_W'(qabs_q);
    mb_a[1] = tdn_pkg::MUL_W'(cabs1_q[1]);  mb_b[1] = tdn_pkg::MUL_W'(qabs_q);
    mb_a[2] = tdn_pkg::MUL_W'(cabs1_q[2]);  mb_b[2] = tdn_pkg::MUL_W'(pabs_q);
    mb_a[3] = tdn_pkg::MUL_W'(pabs_q);      mb_b[3] = tdn_pkg::MUL_W'(pabs_q);
    mb_a[4] = tdn_pkg::MUL_W'(aa_q);        mb_b[4] = tdn_pkg::MUL_W'(radial_q);
  end

  for (genvar i = 0; i < 5; i++) begin : g_mul_b
    tdn_mul u_mul (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (mb_a[i]),
      .b_i   (mb_b[i]),
      .p_o   (mb_p[i])
    );
  end

  logic [ML-1:0]       vb_q;
  logic [ML-1:0][2:0]  gneg_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
    end else if (adv) begin
      vb_q <= {vb_q[ML-2:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gneg_b_q <= {gneg_b_q[ML-2:0], gneg1_q};
    end
  end

  // ---------------------------------------------------------- stage 2: F, |G|
  tdn_pkg::sq_side_t s2_d, s2_q;
  logic              v2_q;

  always_comb begin
    s2_d.f = $signed(tdn_pkg::F_W'(mb_p[3])) - $signed(tdn_pkg::F_W'(mb_p[4]) << 2);
    for (int k = 0; k < 3; k++) begin
      s2_d.gm[k] = tdn_pkg::GM_W'(mb_p[k]) << 2;
    end
    s2_d.gneg = gneg_b_q[ML-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= vb_q[ML-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------- gradient squares
  logic [2:0][tdn_pkg::PROD_W-1:0] mc_p;

  for (genvar i = 0; i < 3; i++) begin : g_mul_c
    tdn_mul u_mul (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (tdn_pkg::MUL_W'(s2_q.gm[i])),
      .b_i   (tdn_pkg::MUL_W'(s2_q.gm[i])),
      .p_o   (mc_p[i])
    );
  end

  logic [ML-1:0]                  vc_q;
  tdn_pkg::sq_side_t [ML-1:0]     side_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= '0;
    end else if (adv) begin
      vc_q <= {vc_q[ML-2:0], v2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_c_q <= {side_c_q[ML-2:0], s2_q};
    end
  end

  // ---------------------------------------------------------- stage 3: |G|^2
  logic [tdn_pkg::G2_W-1:0] g2_q;
  tdn_pkg::sq_side_t        s3_q;
  logic                     v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= vc_q[ML-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g2_q <= tdn_pkg::G2_W'(mc_p[0]) + tdn_pkg::G2_W'(mc_p[1]) + tdn_pkg::G2_W'(mc_p[2]);
      s3_q <= side_c_q[ML-1];
    end
  end

  // ---------------------------------------------------------- gradient length
  logic                        v4;
  logic [tdn_pkg::ROOT_W-1:0]  root;
  tdn_pkg::sq_side_t           s4;

  tdn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   (g2_q),
    .side_i  (s3_q),
    .valid_o (v4),
    .root_o  (root),
    .side_o  (s4)
  );

  // ---------------------------------------------------------- stage 5: numerators
  logic [tdn_pkg::F_W-1:0]                            fabs;
  logic [tdn_pkg::LANES-1:0][tdn_pkg::DIV_W-1:0]      num_d, num_q;
  tdn_pkg::div_side_t                                 ds_d, ds_q;
  logic [tdn_pkg::ROOT_W-1:0]                         den_q;
  logic                                               v5_q;

  always_comb begin
    fabs     = s4.f[tdn_pkg::F_W-1] ? tdn_pkg::F_W'(-s4.f) : tdn_pkg::F_W'(s4.f);
    num_d[0] = tdn_pkg::DIV_W'(fabs);
    for (int k = 0; k < 3; k++) begin
      num_d[k+1] = tdn_pkg::DIV_W'(s4.gm[k]) << tdn_pkg::NORM_FRAC;
    end
    ds_d.fneg  = s4.f[tdn_pkg::F_W-1];
    ds_d.ovf   = tdn_pkg::DIV_W'(fabs) >= (tdn_pkg::DIV_W'(root) << tdn_pkg::QUO_W);
    ds_d.degen = (root == '0);
    ds_d.gneg  = s4.gneg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= num_d;
      den_q <= root;
      ds_q  <= ds_d;
    end
  end

  // ---------------------------------------------------------- divisions
  logic                                          v6;
  logic [tdn_pkg::LANES-1:0][tdn_pkg::QUO_W-1:0] quo;
  tdn_pkg::div_side_t                            ds6;

  tdn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (ds_q),
    .valid_o (v6),
    .quo_o   (quo),
    .side_o  (ds6)
  );

  // ---------------------------------------------------------- result forming
  tdn_pkg::out_item_t              res;
  logic [2:0][tdn_pkg::NORMAL_W-1:0] nmag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nmag[k] = (quo[k+1] > tdn_pkg::NORM_ONE) ? tdn_pkg::NORMAL_W'(tdn_pkg::NORM_ONE)
                                                : tdn_pkg::NORMAL_W'(quo[k+1]);
    end
    res.degenerate = 1'b0;
    res.saturated  = 1'b0;
    res.normal_x   = ds6.gneg[0] ? -$signed(nmag[0]) : $signed(nmag[0]);
    res.normal_y   = ds6.gneg[1] ? -$signed(nmag[1]) : $signed(nmag[1]);
    res.normal_z   = ds6.gneg[2] ? -$signed(nmag[2]) : $signed(nmag[2]);
    if (ds6.fneg) begin
      if (ds6.ovf || quo[0] > tdn_pkg::DIST_NEG_LIM) begin
        res.distance  = $signed(tdn_pkg::DIST_NEG_LIM);
        res.saturated = 1'b1;
      end else begin
        res.distance = $signed(-quo[0]);
      end
    end else begin
      if (ds6.ovf || quo[0][tdn_pkg::COORD_W-1]) begin
        res.distance  = $signed(~tdn_pkg::DIST_NEG_LIM);
        res.saturated = 1'b1;
      end else begin
        res.distance = $signed(quo[0]);
      end
    end
    // zero gradient
    if (ds6.degen) begin
      res.distance   = '0;
      res.normal_x   = '0;
      res.normal_y   = '0;
      res.normal_z   = '0;
      res.degenerate = 1'b1;
      res.saturated  = 1'b0;
    end
  end

  // ---------------------------------------------------------- output register
  tdn_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v6;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

FILE: bench/torus_distance_and_normal_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_distance_and_normal_core_test
// Self-checking bench for the torus distance and normal core: points are
// streamed with random idle and stall, each result is checked against an
// in-bench computation at full width, radii are swept between phases.
// ----------------------------------------------------------------------------
module torus_distance_and_normal_core_test;

  typedef logic signed [255:0] wide_t;

  localparam int DRAIN_CYCLES = 160;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [tdn_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [tdn_pkg::RADIUS_W-1:0]  cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  tdn_pkg::in_item_t             in_item_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  tdn_pkg::out_item_t            out_item_o;

  logic [tdn_pkg::RADIUS_W-1:0]  major_r;
  logic [tdn_pkg::RADIUS_W-1:0]  minor_r;
  tdn_pkg::out_item_t            pending_results[$];
  int                            mismatch_count;
  bit                            quiet;

  torus_distance_and_normal_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  // distance estimate and unit normal of one point at the current radii
  function automatic tdn_pkg::out_item_t torus_eval(tdn_pkg::in_item_t p);
    wide_t x, y, z, a, b, aa, radial, pw, qw, f, g2, len, d, m;
    wide_t rest, trial, bitv, dmax, dmin;
    wide_t g[3];
    logic [tdn_pkg::NORMAL_W-1:0] nrm[3];
    tdn_pkg::out_item_t r;
    x = wide_t'(p.point_x);
    y = wide_t'(p.point_y);
    z = wide_t'(p.point_z);
    a = wide_t'({1'b0, major_r});
    b = wide_t'({1'b0, minor_r});
    aa = a * a;
    radial = x * x + y * y;
    pw = radial + z * z + aa - b * b;
    qw = pw - aa - aa;
    g[0] = 4 * x * qw;
    g[1] = 4 * y * qw;
    g[2] = 4 * z * pw;
    f = pw * pw - 4 * aa * radial;
    g2 = g[0] * g[0] + g[1] * g[1] + g[2] * g[2];
    // floor square root
    rest = g2;
    len = '0;
    bitv = wide_t'(1) <<< 252;
    for (int i = 0; i < 127; i++) begin
      trial = len + bitv;
      len = len >>> 1;
      if (rest >= trial) begin
        rest = rest - trial;
        len = len + bitv;
      end
      bitv = bitv >>> 2;
    end
    r = '0;
    if (len == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    d = f / len;
    dmax = (wide_t'(1) <<< (tdn_pkg::COORD_W - 1)) - 1;
    dmin = -(wide_t'(1) <<< (tdn_pkg::COORD_W - 1));
    if (d > dmax) begin
      d = dmax;
      r.saturated = 1'b1;
    end else if (d < dmin) begin
      d = dmin;
      r.saturated = 1'b1;
    end
    r.distance = d[tdn_pkg::COORD_W-1:0];
    for (int k = 0; k < 3; k++) begin
      m = ((g[k] < 0) ? -g[k] : g[k]) * (wide_t'(1) <<< tdn_pkg::NORM_FRAC) / len;
      if (m > (wide_t'(1) <<< tdn_pkg::NORM_FRAC)) m = wide_t'(1) <<< tdn_pkg::NORM_FRAC;
      if (g[k] < 0) m = -m;
      nrm[k] = m[tdn_pkg::NORMAL_W-1:0];
    end
    r.normal_x = nrm[0];
    r.normal_y = nrm[1];
    r.normal_z = nrm[2];
    return r;
  endfunction

  // result sink: random stall, checked against the oldest expectation
  always @(posedge clk_i) begin
    tdn_pkg::out_item_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item_o !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp dist %0d n %0d %0d %0d deg %b sat %b | "
                     , exp_r.distance, exp_r.normal_x, exp_r.normal_y,
                     exp_r.normal_z, exp_r.degenerate, exp_r.saturated,
                     "got dist %0d n %0d %0d %0d deg %b sat %b",
                     out_item_o.distance, out_item_o.normal_x,
                     out_item_o.normal_y, out_item_o.normal_z,
                     out_item_o.degenerate, out_item_o.saturated);
        end
      end
    end
    out_ready_i <= quiet || ($urandom_range(99) >= 29);
  end

  // send one point, idling a random number of cycles in front
  task automatic send_point(input tdn_pkg::in_item_t p);
    while (!quiet && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(torus_eval(p));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radii(input logic [tdn_pkg::RADIUS_W-1:0] maj,
                             input logic [tdn_pkg::RADIUS_W-1:0] mnr);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tdn_pkg::REG_MAJOR;
    cfg_data_i <= maj;
    @(posedge clk_i);
    cfg_idx_i  <= tdn_pkg::REG_MINOR;
    cfg_data_i <= mnr;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    major_r = maj;
    minor_r = mnr;
  endtask

  function automatic logic [tdn_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 1048576) - 524288;
      2: return $urandom_range(0, 16) - 8;
      default: return $urandom_range(0, 65536 * 64) - 65536 * 32;
    endcase
  endfunction

  function automatic tdn_pkg::in_item_t rand_point();
    tdn_pkg::in_item_t p;
    p.point_x = rand_coord();
    p.point_y = rand_coord();
    p.point_z = rand_coord();
    // points on the axis exercise the near-degenerate region
    if ($urandom_range(9) == 0) begin
      p.point_x = '0;
      p.point_y = '0;
    end
    return p;
  endfunction

  // field extremes, axis, origin and surface points at reset radii, then zero-gradient and saturation cases
  task automatic test_directed();
    logic signed [tdn_pkg::COORD_W-1:0] mx, mn;
    mx = {1'b0, {(tdn_pkg::COORD_W-1){1'b1}}};
    mn = {1'b1, {(tdn_pkg::COORD_W-1){1'b0}}};
    send_point('{32'sd0, 32'sd0, 32'sd0});
    send_point('{mx, mx, mx});
    send_point('{mn, mn, mn});
    send_point('{mx, mn, 32'sd0});
    send_point('{-32'sd1, -32'sd1, -32'sd1});
    send_point('{32'sd1, 32'sd0, 32'sd0});
    send_point('{32'sd196608, 32'sd0, 32'sd0});
    send_point('{32'sd0, -32'sd65536, 32'sd0});
    send_point('{32'sd131072, 32'sd0, 32'sd65536});
    send_point('{32'sd0, 32'sd0, 32'sd65536});
    send_point('{32'sd0, 32'sd0, mn});
    drain();
    // zero gradient away from the origin: tube radius equals axis height
    write_radii('0, 31'd65536);
    send_point('{32'sd0, 32'sd0, 32'sd65536});
    send_point('{32'sd0, 32'sd0, -32'sd65536});
    send_point('{32'sd0, 32'sd0, 32'sd0});
    drain();
    // huge ratio on the axis saturates the distance
    write_radii('1, '0);
    send_point('{32'sd0, 32'sd0, 32'sd1});
    send_point('{32'sd0, 32'sd0, -32'sd1});
    send_point('{mx, 32'sd0, 32'sd0});
    drain();
  endtask

  task automatic test_random_phase(input logic [tdn_pkg::RADIUS_W-1:0] maj,
                                   input logic [tdn_pkg::RADIUS_W-1:0] mnr,
                                   input int count);
    write_radii(maj, mnr);
    for (int i = 0; i < count; i++) send_point(rand_point());
    drain();
  endtask

  // radii sweep including zero and full-scale settings
  task automatic test_radius_sweep();
    test_random_phase(31'd131072, 31'd65536, 380);
    test_random_phase('0, '0, 150);
    test_random_phase('1, '1, 150);
    test_random_phase('1, '0, 150);
    test_random_phase('0, '1, 150);
    quiet = 1'b1;
    test_random_phase(31'd196608, 31'd32768, 300);
    quiet = 1'b0;
    for (int k = 0; k < 4; k++)
      test_random_phase(tdn_pkg::RADIUS_W'($urandom_range(0, 65536 * 16)),
                        tdn_pkg::RADIUS_W'($urandom_range(0, 65536 * 8)), 100);
    test_random_phase(tdn_pkg::RADIUS_W'($urandom), tdn_pkg::RADIUS_W'($urandom), 150);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = tdn_pkg::REG_MAJOR;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_ready_i    = 1'b0;
    major_r        = tdn_pkg::MAJOR_RESET;
    minor_r        = tdn_pkg::MINOR_RESET;
    mismatch_count = 0;
    quiet          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_radius_sweep();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/tdn_pkg.sv
rtl/core/tdn_mul.sv
rtl/core/tdn_sqrt.sv
rtl/core/tdn_div.sv
rtl/core/torus_distance_and_normal_core.sv
bench/torus_distance_and_normal_core_test.sv
